// ===== design/mfcid_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfcid_pkg
// Shared constants, reference tables and types of the MAG image decoder.
// ============================================================================
package mfcid_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int HIST_LINES_DEF = 17;
    localparam int MAX_HEIGHT     = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd400;

    // A flag nibble of this value takes two literal bytes instead of copying.
    localparam logic [3:0] NIB_LITERAL = 4'h0;
    localparam logic [7:0] NIB4_MASK   = 8'h0f;

    // Back-reference offsets: dx in pixel units (4 or 2 pixels), dy in lines.
    localparam logic [2:0] DX_TAB [16] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd0, 3'd1, 3'd0, 3'd1,
                                           3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0};
    localparam logic [4:0] DY_TAB [16] = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
                                           5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd16};

    // One half group of decoded pixels headed for the result buffer.
    typedef struct packed {
        logic            valid;
        logic            fin;
        logic            slot;
        logic            part;
        logic [3:0][7:0] px;
        logic [2:0]      used;
        logic            done;
    } pix_wr_t;

endpackage

// ===== design/mfcid_flag_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfcid_flag_mem
// Per-column flag line memory with one valid bit per entry for fast clearing.
// ============================================================================
module mfcid_flag_mem #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);
    import mfcid_pkg::*;

    logic [7:0]       flag_ram [DEPTH];
    logic [7:0]       rd_word_reg;
    logic             rd_vld_reg;
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            flag_ram[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= flag_ram[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (clear) begin
                vld_reg <= '0;
            end else if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written since the last restart reads as zero.
    assign rd_data = rd_vld_reg ? rd_word_reg : 8'h00;

endmodule

// ===== design/mfcid_hist_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfcid_hist_mem
// Pixel history memory, four pixels a word, with write-to-read forwarding.
// ============================================================================
module mfcid_hist_mem #(
    parameter int DEPTH = 4352,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [3:0][7:0] rd_word,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [3:0][7:0] wr_data,
    input  logic [3:0]      wr_be
);
    import mfcid_pkg::*;

    logic [3:0][7:0] hist_ram [DEPTH];
    logic [3:0][7:0] rd_q_reg;
    logic [AW-1:0]   rd_addr_reg;
    logic [AW-1:0]   lw_addr_reg;
    logic [3:0][7:0] lw_data_reg;
    logic [3:0]      lw_be_reg;
    logic            lw_valid_reg;

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (wr_en && wr_be[b]) begin
                hist_ram[wr_addr][b] <= wr_data[b];
            end
        end
        if (rd_en) begin
            rd_q_reg    <= hist_ram[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
        lw_be_reg   <= wr_be;
    end

    // A read issued on the same edge as a write sees the old word; patch it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else begin
            lw_valid_reg <= rd_en && wr_en;
        end
    end

    always_comb begin
        rd_word = rd_q_reg;
        if (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) begin
            for (int b = 0; b < 4; b++) begin
                if (lw_be_reg[b]) begin
                    rd_word[b] = lw_data_reg[b];
                end
            end
        end
    end

endmodule

// ===== design/mfcid_out_buf.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mfcid_out_buf
// Two-group result buffer that serializes decoded pixels one word a beat.
// ============================================================================
module mfcid_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wide,
    input  logic              reserve,
    output logic              has_space,
    input  mfcid_pkg::pix_wr_t pw,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] pixel_value, [10:8] literal_bytes_used
    output logic              m_tlast,   // last_in_group
    output logic [0:0]        m_tuser    // [0] image_done
);
    import mfcid_pkg::*;

    logic [7:0][7:0] px_reg [2];
    logic [2:0]      used_reg [2];
    logic [1:0]      done_reg;
    logic [1:0]      full_reg;
    logic            rd_slot_reg;
    logic [2:0]      idx_reg;
    logic [1:0]      cnt_reg;
    logic [2:0]      base;
    logic            last_pix;
    logic            beat;
    logic            release_slot;

    assign base = wide ? {1'b0, pw.part, 1'b0} : {pw.part, 2'b00};

    always_ff @(posedge aclk) begin
        if (pw.valid) begin
            for (int i = 0; i < 4; i++) begin
                if (!wide || i < 2) begin
                    px_reg[pw.slot][3'(base + 3'(i))] <= pw.px[i];
                end
            end
            if (pw.fin) begin
                used_reg[pw.slot] <= pw.used;
                done_reg[pw.slot] <= pw.done;
            end
        end
    end

    assign last_pix     = wide ? (idx_reg == 3'd3) : (idx_reg == 3'd7);
    assign m_tvalid     = full_reg[rd_slot_reg];
    assign beat         = m_tvalid && m_tready;
    assign release_slot = beat && last_pix;
    assign m_tdata      = {5'b00000, used_reg[rd_slot_reg], px_reg[rd_slot_reg][idx_reg]};
    assign m_tlast      = last_pix;
    assign m_tuser      = last_pix && done_reg[rd_slot_reg];
    assign has_space    = (cnt_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg    <= 2'b00;
            rd_slot_reg <= 1'b0;
            idx_reg     <= 3'd0;
            cnt_reg     <= 2'd0;
        end else begin
            if (beat) begin
                if (last_pix) begin
                    idx_reg               <= 3'd0;
                    full_reg[rd_slot_reg] <= 1'b0;
                    rd_slot_reg           <= ~rd_slot_reg;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            if (pw.valid && pw.fin) begin
                full_reg[pw.slot] <= 1'b1;
            end
            unique case ({reserve, release_slot})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== design/mag_flag_copy_image_decoder_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mag_flag_copy_image_decoder_top
// MAG pixel-group decoder: flag line, back-reference copy and literal pixels.
// ============================================================================
// The s_ channel takes one group step a word: flag-B byte and four literal
// bytes in s_tdata, the flag-A bit in s_tuser. The m_ channel returns the
// group's pixels left to right, one a word, 8 per group in 16-colour mode and
// 4 in 256-colour mode; m_tlast marks the group's last pixel and m_tuser the
// image's last pixel. The cfg_ channel writes color_mode, image_width and
// image_height while the block is idle; each such write restarts the image.
// A group is not accepted while the flag stage holds another: it reads the flag
// line once and the history memory once per half group over its single read
// port. The pixel output runs one pixel a cycle while m_tready is held high. A
// group passes the flag stage, the first half and the second half before its
// pixels reach the m_ side. A two-group result buffer sits between the decoder
// and m_; when both groups are taken by groups in flight or waiting for the
// receiver, s_tready drops. Reset puts the position at line 0, column 0 and
// clears the flag line through its valid bits at once; the history needs no
// clearing pass since every read either falls above line 0 and reads zero or
// hits a pixel already decoded in the current image.
// ============================================================================
module mag_flag_copy_image_decoder_top #(
    parameter int MAX_WIDTH     = mfcid_pkg::MAX_WIDTH_DEF,
    parameter int HISTORY_LINES = mfcid_pkg::HIST_LINES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,  // [7:0] flag_b_byte, [15:8] lit_byte0,
                                                     // [23:16] lit_byte1, [31:24] lit_byte2,
                                                     // [39:32] lit_byte3
    input  logic [0:0]                     s_tuser,  // [0] flag_a_bit
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // [7:0] pixel_value, [10:8] literal_bytes_used
    output logic                           m_tlast,  // last_in_group
    output logic [0:0]                     m_tuser,  // [0] image_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mfcid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfcid_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mfcid_pkg::*;

    localparam int FD  = MAX_WIDTH / 4;
    localparam int FB  = $clog2(FD);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int WPL = MAX_WIDTH / 4;
    localparam int HD  = HISTORY_LINES * WPL;
    localparam int HB  = $clog2(HD);
    localparam int SB  = $clog2(HISTORY_LINES);
    localparam int SW  = WW + 2;

    typedef struct packed {
        logic [3:0][7:0] lit;
        logic [FB-1:0]   gc;
        logic [9:0]      row;
        logic [SB-1:0]   slot;
        logic            done;
        logic            oslot;
        logic            fa;
        logic [7:0]      fb;
        logic [7:0]      f;
    } grp_t;

    // Configuration and position.
    logic          color_mode_reg;
    logic [10:0]   image_width_reg;
    logic [10:0]   image_height_reg;
    logic [FB-1:0] gc_reg;
    logic [9:0]    row_reg;
    logic [SB-1:0] slot_reg;
    logic          wr_slot_reg;

    logic [WW-1:0] w_eff;
    logic [10:0]   h_eff;
    logic [FB:0]   groups;
    logic          gc_last, row_last, img_last;
    logic          acc, cfg_acc, cfg_restart, restart;
    logic          has_space;

    // Pipeline.
    grp_t st1_reg, st2_reg, st3_reg;
    grp_t st1_upd;
    logic v1_reg, v2_reg, v3_reg;
    logic [7:0] flag_rd, f1;

    // History read issue.
    grp_t          iss;
    logic          iss_part;
    logic [3:0]    iss_nib;
    logic signed [SW-1:0] x0, dxp, s;
    logic [1:0]    wraps;
    logic [11:0]   rr;
    logic [SB+1:0] ss;
    logic [HB-1:0] rd_addr;
    logic          rz_reg, sel_reg;

    // Consume stage.
    grp_t            cons;
    logic            cons_part;
    logic [3:0]      cons_nib;
    logic [2:0]      used_hi, used_tot;
    logic [1:0]      li;
    logic [7:0]      b0, b1;
    logic [3:0][7:0] rd_word, px, wr_data;
    logic [3:0]      wr_be;
    logic [FB-1:0]   wcol;
    logic [HB-1:0]   wr_addr;
    pix_wr_t         pw;

    // ------------------------------------------------------------------------
    // Configuration.
    assign cfg_ready   = 1'b1;
    assign cfg_acc     = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_acc && (cfg_index == REG_COLOR_MODE ||
                                     cfg_index == REG_IMAGE_WIDTH ||
                                     cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg   <= 1'b0;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_acc) begin
            unique case (cfg_index)
                REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          color_mode_reg   <= color_mode_reg;
            endcase
        end
    end

    always_comb begin
        int wi;
        wi = int'({image_width_reg[10:3], 3'b000});
        if (wi < 8) begin
            wi = 8;
        end
        if (wi > MAX_WIDTH) begin
            wi = MAX_WIDTH;
        end
        w_eff = WW'(wi);
        h_eff = image_height_reg;
        if (h_eff == 11'd0) begin
            h_eff = 11'd1;
        end
        if (int'(h_eff) > MAX_HEIGHT) begin
            h_eff = 11'(MAX_HEIGHT);
        end
    end

    assign groups   = color_mode_reg ? (FB+1)'(w_eff >> 2) : (FB+1)'(w_eff >> 3);
    assign gc_last  = (({1'b0, gc_reg} + (FB+1)'(1)) == groups);
    assign row_last = (({1'b0, row_reg} + 11'd1) == h_eff);
    assign img_last = gc_last && row_last;

    // ------------------------------------------------------------------------
    // Input acceptance and position.
    assign s_tready = !v1_reg && has_space;
    assign acc      = s_tvalid && s_tready;
    assign restart  = cfg_restart || (acc && img_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gc_reg      <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            wr_slot_reg <= 1'b0;
        end else begin
            if (acc) begin
                wr_slot_reg <= ~wr_slot_reg;
            end
            if (restart) begin
                gc_reg   <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
            end else if (acc) begin
                if (gc_last) begin
                    gc_reg  <= '0;
                    row_reg <= row_reg + 10'd1;
                    slot_reg <= (slot_reg == SB'(HISTORY_LINES - 1)) ? '0 : slot_reg + SB'(1);
                end else begin
                    gc_reg <= gc_reg + FB'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage registers: flag stage, first half, second half.
    always_comb begin
        st1_upd   = st1_reg;
        st1_upd.f = f1;
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            st1_reg.lit   <= s_tdata[39:8];
            st1_reg.fb    <= s_tdata[7:0];
            st1_reg.fa    <= s_tuser[0];
            st1_reg.gc    <= gc_reg;
            st1_reg.row   <= row_reg;
            st1_reg.slot  <= slot_reg;
            st1_reg.done  <= img_last;
            st1_reg.oslot <= wr_slot_reg;
            st1_reg.f     <= 8'h00;
        end
        st2_reg <= st1_upd;
        st3_reg <= st2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign f1 = flag_rd ^ (st1_reg.fa ? st1_reg.fb : 8'h00);

    // The last group of an image has already cleared the line; it writes nothing.
    mfcid_flag_mem #(.DEPTH(FD)) u_flag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (restart),
        .rd_en   (acc),
        .rd_addr (gc_reg),
        .rd_data (flag_rd),
        .wr_en   (v1_reg && !st1_reg.done),
        .wr_addr (st1_reg.gc),
        .wr_data (f1)
    );

    // ------------------------------------------------------------------------
    // History read issue, half 0 from the flag stage, half 1 in the cycle after.
    always_comb begin
        iss      = st1_reg;
        iss.f    = f1;
        iss_part = 1'b0;
        if (v2_reg) begin
            iss      = st2_reg;
            iss_part = 1'b1;
        end
        iss_nib = iss_part ? iss.f[3:0] : iss.f[7:4];

        if (color_mode_reg) begin
            x0  = SW'({iss.gc, 2'b00}) + SW'({iss_part, 1'b0});
            dxp = SW'({DX_TAB[iss_nib], 1'b0});
        end else begin
            x0  = SW'({iss.gc, 3'b000}) + SW'({iss_part, 2'b00});
            dxp = SW'({DX_TAB[iss_nib], 2'b00});
        end
        s     = x0 - dxp;
        wraps = 2'd0;
        // A narrow line can put the source up to two lines back.
        if (s < 0) begin
            s     = s + SW'(w_eff);
            wraps = 2'd1;
        end
        if (s < 0) begin
            s     = s + SW'(w_eff);
            wraps = 2'd2;
        end
        rr = 12'(iss.row) - 12'(DY_TAB[iss_nib]) - 12'(wraps);
        ss = (SB+2)'(iss.slot) - (SB+2)'(DY_TAB[iss_nib]) - (SB+2)'(wraps);
        if (ss[SB+1]) begin
            ss = ss + (SB+2)'(HISTORY_LINES);
        end
        rd_addr = HB'(ss[SB-1:0] * WPL) + HB'(s[CB-1:2]);
    end

    always_ff @(posedge aclk) begin
        if (v1_reg || v2_reg) begin
            rz_reg  <= rr[11];
            sel_reg <= s[1];
        end
    end

    // ------------------------------------------------------------------------
    // Consume: build half a group of pixels and write it back.
    always_comb begin
        cons      = st2_reg;
        cons_part = 1'b0;
        if (v3_reg) begin
            cons      = st3_reg;
            cons_part = 1'b1;
        end
        cons_nib = cons_part ? cons.f[3:0] : cons.f[7:4];
        used_hi  = (cons.f[7:4] == NIB_LITERAL) ? 3'd2 : 3'd0;
        used_tot = used_hi + ((cons.f[3:0] == NIB_LITERAL) ? 3'd2 : 3'd0);
        li       = cons_part ? used_hi[1:0] : 2'd0;
        b0       = cons.lit[li];
        b1       = cons.lit[2'(li + 2'd1)];

        px = '0;
        if (cons_nib == NIB_LITERAL) begin
            if (color_mode_reg) begin
                px[0] = b0;
                px[1] = b1;
            end else begin
                px[0] = b0 >> 4;
                px[1] = b0 & NIB4_MASK;
                px[2] = b1 >> 4;
                px[3] = b1 & NIB4_MASK;
            end
        end else if (!rz_reg) begin
            if (color_mode_reg) begin
                px[0] = rd_word[{sel_reg, 1'b0}];
                px[1] = rd_word[{sel_reg, 1'b1}];
            end else begin
                px = rd_word;
            end
        end

        if (color_mode_reg) begin
            wcol    = cons.gc;
            wr_data = {px[1], px[0], px[1], px[0]};
            wr_be   = cons_part ? 4'b1100 : 4'b0011;
        end else begin
            wcol    = FB'({cons.gc, cons_part});
            wr_data = px;
            wr_be   = 4'b1111;
        end
        wr_addr = HB'(cons.slot * WPL) + HB'(wcol);

        pw.valid = v2_reg || v3_reg;
        pw.fin   = v3_reg;
        pw.slot  = cons.oslot;
        pw.part  = cons_part;
        pw.px    = px;
        pw.used  = used_tot;
        pw.done  = cons.done;
    end

    mfcid_hist_mem #(.DEPTH(HD)) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (v1_reg || v2_reg),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .wr_en   (v2_reg || v3_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .wr_be   (wr_be)
    );

    mfcid_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wide      (color_mode_reg),
        .reserve   (acc),
        .has_space (has_space),
        .pw        (pw),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // The single history read port serves the flag stage and the second half.
    a_one_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && v2_reg))
        else $error("two history reads issued in one cycle");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v2_reg && v3_reg))
        else $error("two history writes in one cycle");

    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> !s_tready)
        else $error("group accepted in the cycle after another");

endmodule
